>>> design/bounded_key_membership_set_assert.svh
// Assertion macros shared by the bounded key membership set RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef BOUNDED_KEY_MEMBERSHIP_SET_ASSERT_SVH
`define BOUNDED_KEY_MEMBERSHIP_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BKMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bkms assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BKMS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bkms assertion failed");

`endif

>>> design/bkms_pkg.sv
// Shared codes and field widths of the bounded key membership set.
// No dependencies; used by the interfaces and the top module.
package bkms_pkg;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef logic [FUNC_W-1:0]       func_type;
   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [COUNT_W-1:0]      count_type;

endpackage

>>> design/bkms_req_if.sv
// Request channel: one word carries an operation code and a key.
// Depends on bkms_pkg for the field types.
interface bkms_req_if;
   logic                valid;
   logic                ready;
   bkms_pkg::func_type  func;
   bkms_pkg::key_type   key;

   modport source (output valid, output func, output key, input ready);
   modport sink   (input valid, input func, input key, output ready);
endinterface

>>> design/bkms_rsp_if.sv
// Response channel: one word carries membership, status and member count.
// Depends on bkms_pkg for the field types.
interface bkms_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 was_member;
   logic                 status;
   bkms_pkg::count_type  member_count;

   modport source (output valid, output was_member, output status,
                   output member_count, input ready);
   modport sink   (input valid, input was_member, input status,
                   input member_count, output ready);
endinterface

>>> design/bkms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bkms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/bounded_key_membership_set.sv
// Bounded key membership set: a set of up to CAPACITY 32-bit keys that
// answers add, remove and test requests. Every request word returns one
// response word with the prior membership of the key, a full status for a
// refused add, and the member count after the operation. Keys live in one
// RAM and their valid flags in another; a single comparator walks all
// CAPACITY entries through the RAM read port, one entry per cycle, noting
// the matching entry and the lowest free one. A request is accepted in the
// idle state, scanned, and then finished in the update step, which writes
// the RAMs and loads the response register; the update step waits while a
// previous response still waits untaken. The response register lets the
// next request be accepted while a finished response still waits. After
// reset the block runs a clearing pass over the valid RAM; req_ch.ready
// stays low during it.
// Depends on bkms_pkg, bkms_req_if, bkms_rsp_if, bkms_ram and the assertion
// macro header.
`include "bounded_key_membership_set_assert.svh"

module bounded_key_membership_set #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   bkms_req_if.sink    req_ch,
   bkms_rsp_if.source  rsp_ch
);
   import bkms_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST_IDX  = AW'(CAPACITY - 1);
   localparam logic [AW:0]   SCAN_END  = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // Sequencer states.
   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   // Control registers.
   logic [1:0]    state_ff, state_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          hit_ff, hit_in;
   logic          free_found_ff, free_found_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   func_type      func_ff, func_in;
   key_type       key_ff, key_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          was_member_ff, was_member_in;
   logic          status_ff, status_in;
   count_type     member_count_ff, member_count_in;

   // RAM ports.
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          key_wr_en;
   logic          flag_wr_en;
   logic          flag_wr_data;
   logic [AW-1:0] wr_addr;
   key_type       key_rd;
   logic          flag_rd;

   logic          rsp_free;
   logic          entry_match;
   logic [CW-1:0] count_next;
   logic [CW+COUNT_W-1:0] count_ext;

   bkms_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   bkms_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_wr_en),
      .wr_addr (wr_addr),
      .wr_data (flag_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (flag_rd)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // The shared comparator: a live entry whose key equals the request key.
   assign entry_match = flag_rd && (key_rd == key_ff);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      hit_in          = hit_ff;
      free_found_in   = free_found_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      func_in         = func_ff;
      key_in          = key_ff;
      hit_idx_in      = hit_idx_ff;
      free_idx_in     = free_idx_ff;
      was_member_in   = was_member_ff;
      status_in       = status_ff;
      member_count_in = member_count_ff;
      rd_en           = 1'b0;
      rd_addr         = cnt_ff[AW-1:0];
      key_wr_en       = 1'b0;
      flag_wr_en      = 1'b0;
      flag_wr_data    = 1'b0;
      wr_addr         = cnt_ff[AW-1:0];
      count_next      = count_ff;
      count_ext       = '0;

      // A waiting response leaves once it is taken.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            flag_wr_en = 1'b1;
            if (cnt_ff[AW-1:0] == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in       = req_ch.func;
               key_in        = req_ch.key;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               cnt_in        = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != SCAN_END) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (entry_match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (!flag_rd && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               status_in = STATUS_DONE;
               if (func_ff == FUNC_ADD) begin
                  if (!hit_ff && free_found_ff) begin
                     key_wr_en    = 1'b1;
                     flag_wr_en   = 1'b1;
                     flag_wr_data = 1'b1;
                     wr_addr      = free_idx_ff;
                     count_next   = count_ff + 1'b1;
                  end else if (!hit_ff) begin
                     status_in = STATUS_FULL;
                  end
               end else if (func_ff == FUNC_REMOVE) begin
                  if (hit_ff) begin
                     flag_wr_en = 1'b1;
                     wr_addr    = hit_idx_ff;
                     count_next = count_ff - 1'b1;
                  end
               end
               // Test and the unused code leave the set untouched.
               count_ext       = {{COUNT_W{1'b0}}, count_next};
               count_in        = count_next;
               was_member_in   = hit_ff;
               member_count_in = count_ext[COUNT_W-1:0];
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in = rd_en;
      rd_idx_in = cnt_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      key_ff          <= key_in;
      rd_idx_ff       <= rd_idx_in;
      hit_idx_ff      <= hit_idx_in;
      free_idx_ff     <= free_idx_in;
      was_member_ff   <= was_member_in;
      status_ff       <= status_in;
      member_count_ff <= member_count_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.was_member   = was_member_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.member_count = member_count_ff;

   // The member count can never pass the number of entries.
   `BKMS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_COUNT)
   // An accepted request always starts a scan.
   `BKMS_ASSERT_NXT(a_accept_scan, clock, reset, req_ch.valid && req_ch.ready,
                    state_ff == ST_SCAN)
   // A full refusal is only reported when every entry is in use.
   `BKMS_ASSERT_NOW(a_full_status, clock, reset,
                    rsp_ch.valid && (rsp_ch.status == STATUS_FULL),
                    count_ff == CAP_COUNT)
   // The count only moves in the update step.
   `BKMS_ASSERT_NXT(a_count_hold, clock, reset, state_ff != ST_UPDATE,
                    $stable(count_ff))
   // A full refusal never coincides with a hit.
   `BKMS_ASSERT_NOW(a_full_no_hit, clock, reset,
                    rsp_ch.valid && (rsp_ch.status == STATUS_FULL),
                    !rsp_ch.was_member)
endmodule
